>>> rtl/clee_pkg.sv
package clee_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_ONE     = 3'd0;
  localparam logic [2:0] REG_BASE_TWO     = 3'd1;
  localparam logic [2:0] REG_BASE_THREE   = 3'd2;
  localparam logic [2:0] REG_CHASE_STEP   = 3'd3;
  localparam logic [2:0] REG_BREATHE_STEP = 3'd4;
  localparam logic [2:0] REG_SHORT_CHORD  = 3'd5;
  localparam logic [2:0] REG_LONG_CHORD   = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 80;

  // Reset values of the configuration registers
  localparam logic [23:0] BASE_ONE_RST     = 24'hFF0000;
  localparam logic [23:0] BASE_TWO_RST     = 24'h00FF00;
  localparam logic [23:0] BASE_THREE_RST   = 24'h0000FF;
  localparam logic [7:0]  CHASE_STEP_RST   = 8'd150;
  localparam logic [7:0]  BREATHE_STEP_RST = 8'd8;
  localparam logic [15:0] SHORT_CHORD_RST  = 16'd300;
  localparam logic [15:0] LONG_CHORD_RST   = 16'd2000;

  // Chord tracker phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PENDING = 2'd1;
  localparam logic [1:0] PH_LONG    = 2'd2;

  // Effect modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_CHASE   = 2'd1;
  localparam logic [1:0] MODE_BREATHE = 2'd2;

  // Chord events
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // Effect constants
  localparam logic [7:0] HUE_SPAN         = 8'd43;
  localparam logic [7:0] HUE_SCALE        = 8'd6;
  localparam logic [7:0] CHASE_HUE_STEP   = 8'd85;
  localparam logic [7:0] CHASE_VALUE      = 8'd200;
  localparam logic [7:0] CHASE_HUE_ADV    = 8'd16;
  localparam logic [7:0] BREATHE_HALF     = 8'd128;
  localparam logic [7:0] BREATHE_HUE_ADV  = 8'd8;
  localparam logic [1:0] CHASE_LAST_STEP  = 2'd2;

  typedef struct packed {
    logic capture;
    logic eval;
    logic hsv_a;
    logic hsv_b;
    logic load;
  } clee_cmd_t;

endpackage

>>> rtl/clee_ctrl.sv
module clee_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  output clee_pkg::clee_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_HSV_A = 5'b00100,
    ST_HSV_B = 5'b01000,
    ST_LOAD  = 5'b10000
  } clee_state_e;

  clee_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_HSV_A;
      end
      ST_HSV_A: begin
        cmd_o.hsv_a = 1'b1;
        state_d     = ST_HSV_B;
      end
      ST_HSV_B: begin
        cmd_o.hsv_b = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        // hold the finished word until the output register frees up
        if (out_free_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_capture_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.eval)
    else $error("capture not followed by evaluation");

  a_eval_then_hsv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eval |=> cmd_o.hsv_a ##1 cmd_o.hsv_b)
    else $error("hsv stages out of order");

  a_load_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> out_free_i)
    else $error("load into a busy output register");
`endif

endmodule

>>> rtl/clee_dp.sv
module clee_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  clee_pkg::clee_cmd_t                cmd_i,
  output logic                               out_free_o,
  input  logic                               held_i,
  input  logic                               cfg_we_i,
  input  logic [clee_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [clee_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [clee_pkg::M_TDATA_W-1:0]     out_data_o
);

  // Configuration registers
  logic [23:0] base_one_q, base_two_q, base_three_q;
  logic [7:0]  chase_step_q, breathe_step_q;
  logic [15:0] short_chord_q, long_chord_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_one_q     <= clee_pkg::BASE_ONE_RST;
      base_two_q     <= clee_pkg::BASE_TWO_RST;
      base_three_q   <= clee_pkg::BASE_THREE_RST;
      chase_step_q   <= clee_pkg::CHASE_STEP_RST;
      breathe_step_q <= clee_pkg::BREATHE_STEP_RST;
      short_chord_q  <= clee_pkg::SHORT_CHORD_RST;
      long_chord_q   <= clee_pkg::LONG_CHORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clee_pkg::REG_BASE_ONE:     base_one_q     <= cfg_wdata_i;
        clee_pkg::REG_BASE_TWO:     base_two_q     <= cfg_wdata_i;
        clee_pkg::REG_BASE_THREE:   base_three_q   <= cfg_wdata_i;
        clee_pkg::REG_CHASE_STEP:   chase_step_q   <= cfg_wdata_i[7:0];
        clee_pkg::REG_BREATHE_STEP: breathe_step_q <= cfg_wdata_i[7:0];
        clee_pkg::REG_SHORT_CHORD:  short_chord_q  <= cfg_wdata_i[15:0];
        clee_pkg::REG_LONG_CHORD:   long_chord_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Tick state
  logic        held_q;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] held_ms_q, held_ms_d;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  step_q, step_d;
  logic [7:0]  hue_q, hue_d;
  logic [7:0]  elapsed_q, elapsed_d;

  // Per-tick results carried to the output stage
  logic        set_q, written_q, base_sel_q;
  logic [1:0]  event_q;
  logic [7:0]  chase_idx_q;
  logic [7:0]  hsv_h_q, hsv_v_q;

  // Evaluation
  logic [15:0] cnt_inc;
  logic        set_c;
  logic [1:0]  new_mode, event_c, m_c;
  logic [7:0]  step0, hue0, el0, el1, period, step_n, hue_n, inv_step, bright;
  logic [15:0] step_x85;
  logic        anim, fire;

  always_comb begin
    cnt_inc  = held_ms_q;
    phase_d  = phase_q;
    set_c    = 1'b0;
    new_mode = mode_q;
    event_c  = clee_pkg::EV_NONE;

    if (phase_q == clee_pkg::PH_PENDING && held_ms_q != 16'hFFFF) begin
      cnt_inc = held_ms_q + 16'd1;
    end
    held_ms_d = cnt_inc;

    if (held_q) begin
      if (phase_q == clee_pkg::PH_IDLE) begin
        phase_d   = clee_pkg::PH_PENDING;
        held_ms_d = '0;
      end else if (phase_q == clee_pkg::PH_PENDING && cnt_inc >= long_chord_q) begin
        phase_d  = clee_pkg::PH_LONG;
        set_c    = 1'b1;
        new_mode = clee_pkg::MODE_OFF;
        event_c  = clee_pkg::EV_LONG;
      end
    end else begin
      if (phase_q == clee_pkg::PH_PENDING && cnt_inc >= short_chord_q) begin
        set_c   = 1'b1;
        event_c = clee_pkg::EV_SHORT;
        case (mode_q)
          clee_pkg::MODE_OFF:   new_mode = clee_pkg::MODE_CHASE;
          clee_pkg::MODE_CHASE: new_mode = clee_pkg::MODE_BREATHE;
          clee_pkg::MODE_BREATHE: new_mode = clee_pkg::MODE_OFF;
          default:              new_mode = clee_pkg::MODE_CHASE;
        endcase
      end
      phase_d = clee_pkg::PH_IDLE;
    end

    // setting the mode restarts the animation
    m_c   = set_c ? new_mode : mode_q;
    step0 = set_c ? 8'd0 : step_q;
    hue0  = set_c ? 8'd0 : hue_q;
    el0   = set_c ? 8'd0 : elapsed_q;

    anim   = (m_c == clee_pkg::MODE_CHASE) || (m_c == clee_pkg::MODE_BREATHE);
    period = (m_c == clee_pkg::MODE_CHASE) ? chase_step_q : breathe_step_q;
    el1    = (!set_c && el0 != 8'hFF) ? el0 + 8'd1 : el0;
    fire   = anim && (el1 >= period);

    elapsed_d = anim ? (fire ? 8'd0 : el1) : el0;

    inv_step = 8'hFF - step0;
    bright   = (step0 < clee_pkg::BREATHE_HALF) ? {step0[6:0], 1'b0} : {inv_step[6:0], 1'b0};
    step_x85 = {8'd0, step0} * {8'd0, clee_pkg::CHASE_HUE_STEP};

    if (m_c == clee_pkg::MODE_CHASE) begin
      step_n = (step0 >= {6'd0, clee_pkg::CHASE_LAST_STEP}) ? 8'd0 : step0 + 8'd1;
      hue_n  = (step_n == 8'd0) ? hue0 + clee_pkg::CHASE_HUE_ADV : hue0;
    end else begin
      step_n = step0 + 8'd1;
      hue_n  = (step_n == 8'd0) ? hue0 + clee_pkg::BREATHE_HUE_ADV : hue0;
    end

    mode_d = m_c;
    step_d = fire ? step_n : step0;
    hue_d  = fire ? hue_n : hue0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= clee_pkg::PH_IDLE;
      held_ms_q <= '0;
      mode_q    <= clee_pkg::MODE_OFF;
      step_q    <= '0;
      hue_q     <= '0;
      elapsed_q <= '0;
    end else if (cmd_i.eval) begin
      phase_q   <= phase_d;
      held_ms_q <= held_ms_d;
      mode_q    <= mode_d;
      step_q    <= step_d;
      hue_q     <= hue_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      held_q <= held_i;
    end
    if (cmd_i.eval) begin
      set_q       <= set_c;
      event_q     <= event_c;
      base_sel_q  <= set_c && (m_c == clee_pkg::MODE_OFF);
      written_q   <= (set_c && (m_c == clee_pkg::MODE_OFF)) || fire;
      chase_idx_q <= step0;
      hsv_h_q     <= (m_c == clee_pkg::MODE_CHASE) ? hue0 + step_x85[7:0] : hue0;
      hsv_v_q     <= (m_c == clee_pkg::MODE_CHASE) ? clee_pkg::CHASE_VALUE : bright;
    end
  end

  // HSV stage A: hue region and remainder
  logic [2:0]  region_c, region_q;
  logic [7:0]  region_base, hue_off, rem_q;
  logic [10:0] rem_wide;

  always_comb begin
    if (hsv_h_q < clee_pkg::HUE_SPAN) begin
      region_c = 3'd0;
    end else if (hsv_h_q < 8'(2 * clee_pkg::HUE_SPAN)) begin
      region_c = 3'd1;
    end else if (hsv_h_q < 8'(3 * clee_pkg::HUE_SPAN)) begin
      region_c = 3'd2;
    end else if (hsv_h_q < 8'(4 * clee_pkg::HUE_SPAN)) begin
      region_c = 3'd3;
    end else if (hsv_h_q < 8'(5 * clee_pkg::HUE_SPAN)) begin
      region_c = 3'd4;
    end else begin
      region_c = 3'd5;
    end
    region_base = 8'({5'd0, region_c} * clee_pkg::HUE_SPAN);
    hue_off     = hsv_h_q - region_base;
    rem_wide    = {3'd0, hue_off} * {3'd0, clee_pkg::HUE_SCALE};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hsv_a) begin
      region_q <= region_c;
      rem_q    <= rem_wide[7:0];
    end
  end

  // HSV stage B: falling and rising ramps
  logic [15:0] q_prod, t_prod;
  logic [7:0]  q_q, t_q;

  assign q_prod = {8'd0, hsv_v_q} * {8'd0, 8'hFF - rem_q};
  assign t_prod = {8'd0, hsv_v_q} * {8'd0, rem_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.hsv_b) begin
      q_q <= q_prod[15:8];
      t_q <= t_prod[15:8];
    end
  end

  // Output assembly
  logic [7:0]  r_c, g_c, b_c;
  logic [23:0] col, c1, c2, c3;

  always_comb begin
    case (region_q)
      3'd0:    begin r_c = hsv_v_q; g_c = t_q;     b_c = 8'd0;    end
      3'd1:    begin r_c = q_q;     g_c = hsv_v_q; b_c = 8'd0;    end
      3'd2:    begin r_c = 8'd0;    g_c = hsv_v_q; b_c = t_q;     end
      3'd3:    begin r_c = 8'd0;    g_c = q_q;     b_c = hsv_v_q; end
      3'd4:    begin r_c = t_q;     g_c = 8'd0;    b_c = hsv_v_q; end
      default: begin r_c = hsv_v_q; g_c = 8'd0;    b_c = q_q;     end
    endcase
    col = {r_c, g_c, b_c};

    c1 = '0;
    c2 = '0;
    c3 = '0;
    if (base_sel_q) begin
      c1 = base_one_q;
      c2 = base_two_q;
      c3 = base_three_q;
    end else if (written_q) begin
      if (mode_q == clee_pkg::MODE_CHASE) begin
        c1 = (chase_idx_q == 8'd0) ? col : 24'd0;
        c2 = (chase_idx_q == 8'd1) ? col : 24'd0;
        c3 = (chase_idx_q == 8'd2) ? col : 24'd0;
      end else begin
        c1 = col;
        c2 = col;
        c3 = col;
      end
    end
  end

  logic                              out_valid_q;
  logic [clee_pkg::M_TDATA_W-1:0]    out_data_q;

  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= {2'd0, event_q, set_q, mode_q, written_q, c3, c2, c1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == clee_pkg::MODE_OFF || mode_q == clee_pkg::MODE_CHASE ||
    mode_q == clee_pkg::MODE_BREATHE)
    else $error("mode register left the legal modes");

  a_chase_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == clee_pkg::MODE_CHASE |-> step_q <= {6'd0, clee_pkg::CHASE_LAST_STEP})
    else $error("chase step out of range");

  a_report_matches_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[75] == (out_data_q[77:76] != clee_pkg::EV_NONE)))
    else $error("mode report disagrees with chord event");

  a_unwritten_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q[72] |-> out_data_q[71:0] == '0)
    else $error("colors present on an unwritten word");
`endif

endmodule

>>> rtl/chord_led_effect_engine_top.sv
// Chord-driven LED effect engine. Each input word is one millisecond tick whose bit 0 says
// whether all buttons are held; each tick yields exactly one result word with the three
// LED colors, a written flag, the current effect mode, a mode-set flag and the chord event.
// A hold reaching long_chord_ms forces mode off at once; a release after short_chord_ms steps
// off -> rainbow chase -> breathe -> off. A tick is captured at acceptance, then passes the
// state update, hue region and ramp multiply registers; the assembled word is loaded into the
// output register once that register is free, and the next tick is taken only after that
// load, so a new tick is not accepted while one is in flight. The output register lets the
// next tick enter while the previous word is still waiting. Configuration writes take effect
// on the following cycle and belong between ticks.
module chord_led_effect_engine_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] all_buttons_held, [7:1] zero
  input  logic [clee_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [23:0] led_one_color, [47:24] led_two_color, [71:48] led_three_color,
  // [72] leds_written, [74:73] effect_mode_now, [75] mode_report, [77:76] chord_event,
  // [79:78] zero
  output logic [clee_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [clee_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [clee_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  clee_pkg::clee_cmd_t cmd;
  logic                out_free;

  clee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  clee_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .out_free_o  (out_free),
    .held_i      (s_axis_tdata[0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
